/* hdl/fjrb_pkg.sv */
// Shared types and constants of the frame jitter ring buffer.
package fjrb_pkg;

  // Register field widths
  localparam int unsigned FB_W  = 13;
  localparam int unsigned FS_W  = 13;
  localparam int unsigned SPF_W = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned PBL_W = 29;

  // Reset values of the registers
  localparam int unsigned FB_RST  = 160;
  localparam int unsigned FS_RST  = 16;
  localparam int unsigned SPF_RST = 160;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_USER_W = 3;

  // Divider
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd32;

  // Register indexes
  localparam logic [1:0] REG_FRAME_BYTES = 2'd0;
  localparam logic [1:0] REG_FRAME_SLOTS = 2'd1;
  localparam logic [1:0] REG_STEPS       = 2'd2;

  // Operations
  localparam logic [2:0] OP_SEQ    = 3'd0;
  localparam logic [2:0] OP_POS    = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_FLUSH  = 3'd3;
  localparam logic [2:0] OP_SETPOS = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOROOM  = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_DUP     = 3'd4;

  typedef struct packed {
    logic dropped;
    logic positioned;
    logic active;
  } pkt_flags_t;

  // Controller to datapath
  typedef struct packed {
    logic ready;
    logic exec;
    logic div_start;
    logic div_size;
    logic mul;
    logic decide;
    logic start_fin;
    logic load_out;
    logic sz_mul;
    logic sz_fin;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       start;
    logic       ring_zero;
    logic       div_done;
    logic       cfg_hit;
  } sts_t;

endpackage

/* hdl/fjrb_div.sv */
// Bit-serial unsigned divider, 32 by 16 bits, one quotient bit a cycle.
module fjrb_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [15:0] rem_o
);
  import fjrb_pkg::*;

  logic [15:0]          rem_q, dsr_q;
  logic [31:0]          quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [16:0]          shf, dif;

  // restoring step
  assign shf = {rem_q, quo_q[31]};
  assign dif = shf - {1'b0, dsr_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= dif[16] ? shf[15:0] : dif[15:0];
      quo_q <= {quo_q[30:0], ~dif[16]};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

/* hdl/fjrb_datapath.sv */
// Datapath: ring store, indices, packet state, registers and result register.
module fjrb_datapath #(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fjrb_pkg::cmd_t                      cmd_i,
  output fjrb_pkg::sts_t                      sts_o,
  input  logic                                in_valid_i,
  input  logic [fjrb_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic [fjrb_pkg::IN_USER_W-1:0]      in_user_i,
  output logic [fjrb_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic [fjrb_pkg::OUT_USER_W-1:0]     out_user_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [fjrb_pkg::CFG_W-1:0]          cfg_data_i
);
  import fjrb_pkg::*;

  localparam int unsigned IW  = $clog2(STORE_BYTES);
  localparam int unsigned CW  = $clog2(STORE_BYTES + 1);
  localparam int unsigned SW  = ((CW > FB_W) ? CW : FB_W) + 1;
  localparam int unsigned NBW = CW + FB_W;
  localparam int unsigned RST_CAP  = FB_RST * FS_RST;
  localparam int unsigned RST_RING = (RST_CAP > STORE_BYTES) ?
                                     STORE_BYTES - STORE_BYTES % FB_RST : RST_CAP;

  // registers
  logic [FB_W-1:0]  fb_q, fb_d;
  logic [FS_W-1:0]  fs_q, fs_d;
  logic [SPF_W-1:0] spf_q, spf_d;
  logic [CW-1:0]    ring_q, ring_d;
  logic [IW-1:0]    wi_q, wi_d, ri_q, ri_d, pidx_q, pidx_d;
  logic [31:0]      pos_q, pos_d, pend_q, pend_d;
  logic [PBL_W-1:0] pbl_q, pbl_d, skip_q, skip_d;
  logic [FB_W-1:0]  bif_q, bif_d;
  pkt_flags_t       flags_q, flags_d;
  logic [2:0]       drop_q, drop_d, st_q, st_d;
  logic             rd_sel_q, rd_sel_d;
  logic [7:0]       rdata_q;
  logic [7:0]       ring_mem_q [STORE_BYTES];

  // item
  logic [2:0]  op_q;
  logic        start_q;
  logic [7:0]  din_q;
  logic [15:0] frames_q;
  logic [31:0] spos_q;

  // start temporaries
  logic [31:0]     prod_q, prod_d, diff_q, diff_d;
  logic [NBW-1:0]  nb_q, nb_d;
  logic            big_q, big_d, qnz_q, qnz_d;
  logic [FB_W+FS_W-1:0] cap_q, cap_d;

  // divider
  logic        div_done;
  logic [31:0] div_quot, div_dend;
  logic [15:0] div_rem, div_dsr;

  // memory port
  logic          we, rd_en;
  logic [IW-1:0] waddr;

  // derived values
  logic [SW-1:0] ring_w, wi_w, ri_w, pidx_w, fb_w, p_w, room_w, nx_w, np_w, uns_w;
  logic [SW-1:0] ri_inc;
  logic [FB_W-1:0] bif_inc;
  logic fits, frame_end, commit_gt, cfg_hit;

  assign ring_w = SW'(ring_q);
  assign wi_w   = SW'(wi_q);
  assign ri_w   = SW'(ri_q);
  assign pidx_w = SW'(pidx_q);
  assign fb_w   = SW'(fb_q);

  // frame base, wrapped at the start of a frame
  assign p_w    = (bif_q == '0 && pidx_w >= ring_w) ? '0 : pidx_w;
  assign room_w = (p_w >= ri_w) ? ring_w - p_w : ri_w - p_w;
  assign nx_w   = p_w + fb_w;
  assign np_w   = (nx_w >= ring_w) ? '0 : nx_w;
  assign fits   = (room_w >= fb_w) && (np_w != ri_w);
  assign bif_inc   = bif_q + 1'b1;
  assign frame_end = bif_inc >= fb_q;
  assign commit_gt = pend_q > pos_q;
  assign ri_inc    = ri_w + 1'b1;

  // unsent byte count
  always_comb begin
    if (ring_q == '0)       uns_w = '0;
    else if (wi_q >= ri_q)  uns_w = wi_w - ri_w;
    else                    uns_w = ring_w - ri_w + wi_w;
  end

  assign cfg_hit = cfg_we_i && (cfg_index_i == REG_FRAME_BYTES ||
                                cfg_index_i == REG_FRAME_SLOTS ||
                                cfg_index_i == REG_STEPS);

  // shared divider: ring sizing or frame offset
  assign div_dend = cmd_i.div_size ? 32'(STORE_BYTES) :
                    (diff_q[31] ? (~diff_q + 32'd1) : diff_q);
  assign div_dsr  = cmd_i.div_size ? 16'(fb_q) :
                    ((spf_q == '0) ? 16'd1 : spf_q);

  fjrb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dend),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // next state
  always_comb begin
    logic          do_byte;
    logic          dropped_n;
    logic [SW-1:0] sum;
    logic [SW-1:0] pn;

    fb_d = fb_q;  fs_d = fs_q;  spf_d = spf_q;  ring_d = ring_q;
    wi_d = wi_q;  ri_d = ri_q;  pidx_d = pidx_q; pos_d = pos_q; pend_d = pend_q;
    pbl_d = pbl_q; skip_d = skip_q; bif_d = bif_q; flags_d = flags_q;
    drop_d = drop_q; st_d = st_q; rd_sel_d = rd_sel_q;
    prod_d = prod_q; diff_d = diff_q; nb_d = nb_q; big_d = big_q; qnz_d = qnz_q;
    cap_d = cap_q;
    we = 1'b0; rd_en = 1'b0; waddr = '0;
    do_byte = 1'b0; dropped_n = flags_q.dropped; sum = '0; pn = '0;

    // configuration write resizes and flushes
    if (cfg_hit) begin
      unique case (cfg_index_i)
        REG_FRAME_BYTES: fb_d  = cfg_data_i[FB_W-1:0];
        REG_FRAME_SLOTS: fs_d  = cfg_data_i[FS_W-1:0];
        REG_STEPS:       spf_d = cfg_data_i[SPF_W-1:0];
        default: ;
      endcase
      wi_d = '0; ri_d = '0; flags_d = '0; pbl_d = '0; skip_d = '0; bif_d = '0;
    end

    // ring sizing
    if (cmd_i.sz_mul) cap_d = fb_q * fs_q;
    if (cmd_i.sz_fin) begin
      if (cap_q > (FB_W+FS_W)'(STORE_BYTES))
        ring_d = CW'(STORE_BYTES - 32'(div_rem));
      else
        ring_d = CW'(cap_q);
    end

    // item dispatch
    if (cmd_i.exec) begin
      st_d = ST_OK;
      rd_sel_d = 1'b0;
      case (op_q) inside
        OP_SEQ, OP_POS: begin
          if (start_q) begin
            if (ring_q == '0) begin
              flags_d = '0;
              st_d = ST_NOROOM;
            end else begin
              flags_d = '{dropped: 1'b0, positioned: (op_q == OP_POS), active: 1'b1};
              pbl_d  = PBL_W'(frames_q * fb_q);
              skip_d = '0;
              bif_d  = '0;
              pidx_d = wi_q;
              drop_d = ST_OK;
              prod_d = 32'(frames_q * spf_q);
              diff_d = spos_q - pos_q;
            end
          end else begin
            do_byte = 1'b1;
          end
        end
        OP_READ: begin
          if (uns_w == '0) begin
            st_d = ST_EMPTY;
          end else begin
            rd_en = 1'b1;
            rd_sel_d = 1'b1;
            ri_d = (ri_inc >= ring_w) ? '0 : IW'(ri_inc);
          end
        end
        OP_FLUSH: begin
          wi_d = '0; ri_d = '0; flags_d = '0; pbl_d = '0; skip_d = '0; bif_d = '0;
        end
        OP_SETPOS: pos_d = spos_q;
        default: ;
      endcase
    end

    // offset magnitude in bytes and packet end position
    if (cmd_i.mul) begin
      nb_d   = NBW'(div_quot[CW-1:0] * fb_q);
      big_d  = (div_quot >> CW) != '0;
      qnz_d  = div_quot != '0;
      pend_d = spos_q + prod_q;
    end

    // place the positioned packet
    if (cmd_i.decide && qnz_q) begin
      if (big_q || nb_q >= NBW'(ring_q)) begin
        flags_d.dropped = 1'b1;
        drop_d = ST_RANGE;
      end else if (!diff_q[31]) begin
        sum = wi_w + SW'(nb_q);
        if (sum >= ring_w) sum = sum - ring_w;
        pidx_d = IW'(sum);
      end else if (pend_q < pos_q) begin
        sum = wi_w + ring_w - SW'(nb_q);
        if (sum >= ring_w) sum = sum - ring_w;
        pidx_d = IW'(sum);
      end else begin
        skip_d = (PBL_W'(nb_q) < pbl_q) ? PBL_W'(nb_q) : pbl_q;
      end
    end

    // first byte, or an empty packet
    if (cmd_i.start_fin) begin
      if (pbl_q == '0) begin
        st_d = flags_q.dropped ? drop_q : ST_OK;
        if (flags_q.positioned && !flags_q.dropped && commit_gt) begin
          wi_d  = (pidx_w >= ring_w) ? '0 : pidx_q;
          pos_d = pend_q;
        end
        flags_d = '0;
      end else begin
        st_d = ST_OK;
        rd_sel_d = 1'b0;
        do_byte = 1'b1;
      end
    end

    // one packet byte
    if (do_byte) begin
      if (!flags_q.active || pbl_q == '0) begin
        flags_d = '0;
        st_d = ST_NOROOM;
      end else begin
        if (flags_q.dropped) begin
          st_d = drop_q;
        end else if (skip_q != '0) begin
          skip_d = skip_q - 1'b1;
          st_d = ST_DUP;
        end else begin
          if (bif_q == '0) pidx_d = IW'(p_w);
          if (bif_q == '0 && !fits) begin
            // no room: positioned packet commits what it has
            if (flags_q.positioned && commit_gt) begin
              wi_d  = IW'(p_w);
              pos_d = pend_q;
            end
            dropped_n = 1'b1;
            drop_d = ST_NOROOM;
            st_d = ST_NOROOM;
          end else begin
            st_d  = ST_OK;
            we    = 1'b1;
            waddr = IW'(p_w + SW'(bif_q));
            if (frame_end) begin
              bif_d  = '0;
              pidx_d = IW'(np_w);
              if (!flags_q.positioned) begin
                wi_d  = IW'(np_w);
                pos_d = pos_q + 32'(spf_q);
              end
            end else begin
              bif_d = bif_inc;
            end
          end
        end
        pbl_d = pbl_q - 1'b1;
        flags_d.dropped = dropped_n;
        // packet end
        if (pbl_q == PBL_W'(1)) begin
          pn = SW'(pidx_d);
          if (flags_q.positioned && !dropped_n && commit_gt) begin
            wi_d  = (pn >= ring_w) ? '0 : pidx_d;
            pos_d = pend_q;
          end
          flags_d = '0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q    <= FB_W'(FB_RST);
      fs_q    <= FS_W'(FS_RST);
      spf_q   <= SPF_W'(SPF_RST);
      ring_q  <= CW'(RST_RING);
      wi_q    <= '0;
      ri_q    <= '0;
      pidx_q  <= '0;
      pos_q   <= '0;
      pend_q  <= '0;
      pbl_q   <= '0;
      skip_q  <= '0;
      bif_q   <= '0;
      flags_q <= '0;
      drop_q  <= ST_OK;
    end else begin
      fb_q    <= fb_d;
      fs_q    <= fs_d;
      spf_q   <= spf_d;
      ring_q  <= ring_d;
      wi_q    <= wi_d;
      ri_q    <= ri_d;
      pidx_q  <= pidx_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      pbl_q   <= pbl_d;
      skip_q  <= skip_d;
      bif_q   <= bif_d;
      flags_q <= flags_d;
      drop_q  <= drop_d;
    end
  end

  // payload and temporaries
  always_ff @(posedge clk_i) begin
    st_q     <= st_d;
    rd_sel_q <= rd_sel_d;
    prod_q   <= prod_d;
    diff_q   <= diff_d;
    nb_q     <= nb_d;
    big_q    <= big_d;
    qnz_q    <= qnz_d;
    cap_q    <= cap_d;
    if (cmd_i.ready && in_valid_i) begin
      op_q     <= in_user_i[2:0];
      start_q  <= in_user_i[3];
      din_q    <= in_data_i[7:0];
      frames_q <= in_data_i[23:8];
      spos_q   <= in_data_i[55:24];
    end
  end

  // ring store: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) ring_mem_q[waddr] <= din_q;
    if (rd_en) rdata_q <= ring_mem_q[ri_q];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_user_o <= st_q;
      out_data_o <= {5'b0, pos_q, (fb_q != '0 && uns_w >= fb_w), 13'(uns_w),
                     13'(ring_w - uns_w), (rd_sel_q ? rdata_q : 8'd0)};
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.start     = start_q;
  assign sts_o.ring_zero = ring_q == '0;
  assign sts_o.div_done  = div_done;
  assign sts_o.cfg_hit   = cfg_hit;

endmodule

/* hdl/fjrb_ctrl.sv */
// Controller: sequences each item, ring sizing and the result handshake.
module fjrb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  input  fjrb_pkg::sts_t sts_i,
  output fjrb_pkg::cmd_t cmd_o
);
  import fjrb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DIV_GO, S_DIV_WAIT, S_MUL, S_DECIDE, S_START_FIN, S_OUT,
    S_SZ_MUL, S_SZ_GO, S_SZ_WAIT, S_SZ_FIN
  } state_e;

  state_e state_q;
  logic   size_pend_q, out_valid_q;

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:      cmd_o.ready = !size_pend_q;
      S_EXEC:      cmd_o.exec = 1'b1;
      S_DIV_GO:    cmd_o.div_start = 1'b1;
      S_DIV_WAIT:  ;
      S_MUL:       cmd_o.mul = 1'b1;
      S_DECIDE:    cmd_o.decide = 1'b1;
      S_START_FIN: cmd_o.start_fin = 1'b1;
      S_OUT:       cmd_o.load_out = !out_valid_q || out_ready_i;
      S_SZ_MUL:    cmd_o.sz_mul = 1'b1;
      S_SZ_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_size  = 1'b1;
      end
      S_SZ_WAIT:   cmd_o.div_size = 1'b1;
      S_SZ_FIN:    cmd_o.sz_fin = 1'b1;
      default: ;
    endcase
  end

  // state, sizing request and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      if (sts_i.cfg_hit) size_pend_q <= 1'b1;
      else if (state_q == S_IDLE && size_pend_q) size_pend_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (size_pend_q)     state_q <= S_SZ_MUL;
          else if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if ((sts_i.op == OP_SEQ || sts_i.op == OP_POS) && sts_i.start &&
              !sts_i.ring_zero)
            state_q <= (sts_i.op == OP_POS) ? S_DIV_GO : S_START_FIN;
          else
            state_q <= S_OUT;
        end
        S_DIV_GO:    state_q <= S_DIV_WAIT;
        S_DIV_WAIT:  if (sts_i.div_done) state_q <= S_MUL;
        S_MUL:       state_q <= S_DECIDE;
        S_DECIDE:    state_q <= S_START_FIN;
        S_START_FIN: state_q <= S_OUT;
        S_OUT:       if (cmd_o.load_out) state_q <= S_IDLE;
        S_SZ_MUL:    state_q <= S_SZ_GO;
        S_SZ_GO:     state_q <= S_SZ_WAIT;
        S_SZ_WAIT:   if (sts_i.div_done) state_q <= S_SZ_FIN;
        S_SZ_FIN:    state_q <= S_IDLE;
        default:     state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/frame_jitter_ring_buffer_core.sv */
// Top level of the frame jitter ring buffer.
// Byte-wide jitter buffer holding whole frames in a ring of STORE_BYTES bytes.
// One item is taken at a time and gives one result transfer. Reads, flushes,
// position sets and continuing packet bytes pass through accept, execute and
// load of the result register; the first byte of a sequential packet adds a
// start step before the load. The first byte of a positioned packet also runs
// the bit-serial offset divider (32 steps), a multiply and a placement step.
// After a register write the ring size is recomputed on the same divider,
// holding s_axis_tready low until it is done. The result register lets the
// next item be taken while a result still waits on the master side.
module frame_jitter_ring_buffer_core #(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // data_in[7:0], packet_frames[23:8], stream_position[55:24]
  input  logic [fjrb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // op[2:0], packet_start[3]
  input  logic [fjrb_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // data_out[7:0], free_bytes[20:8], unsent_bytes[33:21], frame_ready[34],
  // write_position[66:35], zero pad above
  output logic [fjrb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status[2:0]
  output logic [fjrb_pkg::OUT_USER_W-1:0]     m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [fjrb_pkg::CFG_W-1:0]          cfg_data_i
);
  import fjrb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fjrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fjrb_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  assign s_axis_tready = cmd.ready;

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transfer accepted while an item is in flight");

  // the result register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register loaded over an untaken result");

  // a register write blocks input until the ring is resized
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.cfg_hit |=> !s_axis_tready)
    else $error("input accepted before ring resize");

endmodule

/* dv/frame_jitter_ring_buffer_core_tb.sv */
// Self-checking testbench of the frame jitter ring buffer core.
`timescale 1ns / 1ps

module frame_jitter_ring_buffer_core_tb;
  import fjrb_pkg::*;

  localparam int unsigned STORE = 4096;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  data;
    logic        start;
    logic [15:0] frames;
    logic [31:0] spos;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  dout;
    logic [12:0] free;
    logic [12:0] unsent;
    logic        ready;
    logic [31:0] wpos;
  } ring_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [IN_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  frame_jitter_ring_buffer_core u_top (.*);

  always #5 clk_i = ~clk_i;

  byte_item_t   pending_items[$];
  ring_result_t expected_results[$];
  int unsigned  mismatches = 0;
  int unsigned  sent_items = 0;
  int unsigned  queued_items = 0;
  bit           burst_in = 0;
  bit           burst_out = 0;

  // Shadow of the ring state
  logic [7:0]  shadow_mem [STORE];
  bit          shadow_written [STORE];
  logic [31:0] fb, fs, spf, rb;
  logic [31:0] wr_idx, rd_idx, step_pos, pkt_idx, pkt_left, skip_left, in_frame;
  logic [31:0] end_pos, drop_st;
  bit          f_act, f_pos, f_drop;

  function automatic void size_ring();
    logic [31:0] cap;
    cap = fb * fs;
    if (cap > STORE) cap = STORE;
    rb = (fb != 0) ? (cap / fb) * fb : 0;
  endfunction

  function automatic logic [31:0] unsent_now();
    if (rb == 0) return 0;
    if (wr_idx >= rd_idx) return wr_idx - rd_idx;
    return rb - rd_idx + wr_idx;
  endfunction

  function automatic void clear_ring();
    wr_idx = 0; rd_idx = 0; f_act = 0; f_pos = 0; f_drop = 0;
    pkt_left = 0; skip_left = 0; in_frame = 0;
  endfunction

  function automatic void commit_jump();
    if (end_pos > step_pos) begin
      wr_idx = (pkt_idx >= rb) ? 0 : pkt_idx;
      step_pos = end_pos;
    end
  endfunction

  function automatic void end_packet();
    if (f_pos && !f_drop) commit_jump();
    f_act = 0; f_pos = 0; f_drop = 0;
  endfunction

  function automatic bit room_for_frame(logic [31:0] p);
    logic [31:0] room, nxt;
    room = (p >= rd_idx) ? rb - p : rd_idx - p;
    nxt = p + fb;
    if (nxt >= rb) nxt = 0;
    return room >= fb && nxt != rd_idx;
  endfunction

  function automatic logic [2:0] take_byte(logic [7:0] d);
    logic [2:0]  st;
    logic [31:0] idx;
    st = ST_OK;
    if (!f_act || pkt_left == 0) begin
      f_act = 0; f_pos = 0; f_drop = 0;
      return ST_NOROOM;
    end
    if (f_drop) st = drop_st[2:0];
    else if (skip_left > 0) begin
      skip_left--;
      st = ST_DUP;
    end else begin
      if (in_frame == 0) begin
        if (pkt_idx >= rb) pkt_idx = 0;
        if (!room_for_frame(pkt_idx)) begin
          if (f_pos) commit_jump();
          f_drop = 1; drop_st = ST_NOROOM; st = ST_NOROOM;
        end
      end
      if (st == ST_OK) begin
        idx = pkt_idx + in_frame;
        if (idx < STORE) begin
          shadow_mem[idx] = d;
          shadow_written[idx] = 1;
        end
        in_frame++;
        if (in_frame >= fb) begin
          in_frame = 0;
          pkt_idx += fb;
          if (pkt_idx >= rb) pkt_idx = 0;
          if (!f_pos) begin
            wr_idx = pkt_idx;
            step_pos += spf;
          end
        end
      end
    end
    pkt_left--;
    if (pkt_left == 0) end_packet();
    return st;
  endfunction

  function automatic logic [2:0] open_packet(byte_item_t it);
    logic [31:0] diff;
    longint      d, dv, rel, nb;
    logic [2:0]  st;
    if (rb == 0) begin
      f_act = 0; f_pos = 0; f_drop = 0;
      return ST_NOROOM;
    end
    f_act = 1; f_pos = (it.op == OP_POS); f_drop = 0;
    pkt_left = it.frames * fb;
    skip_left = 0; in_frame = 0; pkt_idx = wr_idx; drop_st = ST_OK;
    if (it.op == OP_POS) begin
      diff = it.spos - step_pos;
      d = longint'($signed(diff));
      dv = (spf != 0) ? longint'(spf) : 1;
      rel = d / dv;
      end_pos = it.spos + it.frames * spf;
      if (rel != 0) begin
        nb = (rel < 0 ? -rel : rel) * longint'(fb);
        if (nb >= longint'(rb)) begin
          f_drop = 1; drop_st = ST_RANGE;
        end else if (rel > 0) begin
          pkt_idx = wr_idx + nb[31:0];
          if (pkt_idx >= rb) pkt_idx -= rb;
        end else if (end_pos < step_pos) begin
          pkt_idx = wr_idx + rb - nb[31:0];
          if (pkt_idx >= rb) pkt_idx -= rb;
        end else begin
          skip_left = (nb < longint'(pkt_left)) ? nb[31:0] : pkt_left;
        end
      end
    end
    if (pkt_left == 0) begin
      st = f_drop ? drop_st[2:0] : ST_OK;
      end_packet();
      return st;
    end
    return take_byte(it.data);
  endfunction

  function automatic ring_result_t ring_predict(byte_item_t it);
    ring_result_t r;
    logic [31:0]  u;
    r.status = ST_OK;
    r.dout = '0;
    case (it.op)
      OP_SEQ, OP_POS: begin
        r.status = it.start ? open_packet(it) : take_byte(it.data);
      end
      OP_READ: begin
        if (unsent_now() == 0) r.status = ST_EMPTY;
        else begin
          r.dout = shadow_mem[rd_idx];
          rd_idx++;
          if (rd_idx >= rb) rd_idx = 0;
        end
      end
      OP_FLUSH: clear_ring();
      OP_SETPOS: step_pos = it.spos;
      default: ;
    endcase
    u = unsent_now();
    r.free = 13'(rb - u);
    r.unsent = u[12:0];
    r.ready = (fb != 0 && u >= fb);
    r.wpos = step_pos;
    return r;
  endfunction

  // Queue one item with its expected result
  task automatic add_item(logic [2:0] op, logic [7:0] d, logic st, logic [15:0] fr,
                          logic [31:0] sp);
    byte_item_t it;
    it.op = op; it.data = d; it.start = st; it.frames = fr; it.spos = sp;
    // reads of never-written entries are not allowed
    if (op == OP_READ && unsent_now() != 0 && !shadow_written[rd_idx]) return;
    expected_results.push_back(ring_predict(it));
    pending_items.push_back(it);
    queued_items++;
  endtask

  // First byte plus up to max_bytes-1 continuation bytes
  task automatic add_packet(logic [2:0] op, logic [15:0] fr, logic [31:0] sp,
                            int unsigned max_bytes);
    int unsigned n;
    n = fr * fb;
    if (n > max_bytes) n = max_bytes;
    if (n == 0) n = 1;
    add_item(op, 8'($urandom), 1'b1, fr, sp);
    for (int unsigned i = 1; i < n; i++)
      add_item(op, 8'($urandom), 1'b0, 16'($urandom), $urandom);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FRAME_BYTES: fb = val & 16'h1FFF;
      REG_FRAME_SLOTS: fs = val & 16'h1FFF;
      default:         spf = val;
    endcase
    size_ring();
    clear_ring();
  endtask

  task automatic set_ring(int unsigned b, int unsigned s, int unsigned p);
    wait_idle();
    write_reg(REG_FRAME_BYTES, CFG_W'(b));
    write_reg(REG_FRAME_SLOTS, CFG_W'(s));
    write_reg(REG_STEPS, CFG_W'(p));
    repeat (60) @(posedge clk_i);
  endtask

  // Mixed random traffic of about count items, mostly well-formed packets
  task automatic random_traffic(int unsigned count);
    int unsigned target;
    logic [15:0] fr;
    logic [31:0] sp;
    target = queued_items + count;
    while (queued_items < target) begin
      if ($urandom_range(0, 99) < 8) begin
        burst_in = $urandom_range(0, 1);
        burst_out = $urandom_range(0, 1);
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          fr = ($urandom_range(0, 19) == 0) ? 16'($urandom) :
               16'($urandom_range(0, 3));
          add_packet(OP_SEQ, fr, $urandom, $urandom_range(0, 5) == 0 ?
                     $urandom_range(1, 8) : 40);
        end
        6, 7, 8, 9, 10: begin
          fr = 16'($urandom_range(0, 3));
          if ($urandom_range(0, 9) == 0) sp = $urandom;
          else sp = step_pos + (int'($urandom_range(0, 12)) - 5) * int'(spf)
                    + $urandom_range(0, 2);
          add_packet(OP_POS, fr, sp, $urandom_range(0, 5) == 0 ?
                     $urandom_range(1, 8) : 40);
        end
        11, 12, 13, 14, 15: begin
          repeat ($urandom_range(1, 10)) add_item(OP_READ, 8'($urandom), $urandom,
                                                  16'($urandom), $urandom);
        end
        16: add_item(OP_FLUSH, 8'($urandom), $urandom, 16'($urandom), $urandom);
        17: add_item(OP_SETPOS, 8'($urandom), $urandom, 16'($urandom),
                     $urandom_range(0, 1) ? $urandom : step_pos + $urandom_range(0, 50));
        18: add_item(OP_SEQ, 8'($urandom), 1'b0, 16'($urandom), $urandom);
        default: add_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 8'($urandom),
                          $urandom, 16'($urandom), $urandom);
      endcase
      while (expected_results.size() > 200) @(posedge clk_i);
    end
  endtask

  // Stimulus
  initial begin
    fb = FB_RST; fs = FS_RST; spf = SPF_RST;
    size_ring();
    clear_ring();
    step_pos = 0; pkt_idx = 0; end_pos = 0; drop_st = 0;
    foreach (shadow_written[i]) shadow_written[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_ring(4, 8, 10);

    // directed corner cases
    add_item(OP_READ, 8'h00, 1'b0, 16'h0000, 32'h0);
    add_item(OP_SEQ, 8'hFF, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);      // stray byte
    add_packet(OP_SEQ, 16'd1, 32'h0, 40);
    add_packet(OP_POS, 16'd1, 32'd0, 40);                         // duplicate
    add_packet(OP_POS, 16'd1, 32'd40, 40);                        // jump ahead
    add_packet(OP_POS, 16'd1, 32'd15, 40);                        // fills the gap
    add_packet(OP_POS, 16'd1, 32'd100000, 40);                    // out of range
    add_packet(OP_SEQ, 16'd0, 32'h0, 40);                         // zero frames
    add_packet(OP_POS, 16'd0, 32'd200, 40);
    add_packet(OP_SEQ, 16'hFFFF, 32'h0, 3);                       // interrupted
    add_packet(OP_SEQ, 16'd8, 32'h0, 40);                         // runs out of room
    repeat (6) add_item(OP_READ, 8'h00, 1'b0, 16'h0, 32'h0);
    add_item(OP_SETPOS, 8'h00, 1'b0, 16'h0, 32'hFFFF_FFFF);
    add_item(OP_SPARE_LO, 8'hA5, 1'b1, 16'h1234, 32'h8000_0000);
    add_item(OP_SPARE_HI, 8'h5A, 1'b0, 16'h4321, 32'h7FFF_FFFF);
    add_item(OP_FLUSH, 8'h00, 1'b0, 16'h0, 32'h0);
    random_traffic(680);

    set_ring(1, 4096, 1);
    random_traffic(300);
    set_ring(3, 5, 0);
    random_traffic(300);
    set_ring(4096, 4096, 65535);
    random_traffic(60);
    set_ring(0, 7, 100);
    random_traffic(60);
    set_ring(7, 0, 100);
    random_traffic(30);
    set_ring(7, 3, 100);
    random_traffic(300);
    set_ring(160, 16, 160);
    random_traffic(150);
    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Driver
  int unsigned in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    bit         vld;
    byte_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      vld = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        vld = 1'b0;
        sent_items++;
        in_gap = burst_in ? 0 : $urandom_range(0, 15);
      end
      if (!vld) begin
        if (in_gap > 0) in_gap--;
        else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          s_axis_tdata <= {it.spos, it.frames, it.data};
          s_axis_tuser <= {it.start, it.op};
          vld = 1'b1;
        end
      end
      s_axis_tvalid <= vld;
    end
  end

  // Monitor
  int unsigned out_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    ring_result_t e, a;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        a.status = m_axis_tuser[2:0];
        a.dout = m_axis_tdata[7:0];
        a.free = m_axis_tdata[20:8];
        a.unsent = m_axis_tdata[33:21];
        a.ready = m_axis_tdata[34];
        a.wpos = m_axis_tdata[66:35];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: status %0d", a.status);
        end else begin
          e = expected_results.pop_front();
          if (a != e) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp st=%0d d=%h free=%0d uns=%0d rdy=%0b pos=%h",
                       e.status, e.dout, e.free, e.unsent, e.ready, e.wpos);
              $display("          act st=%0d d=%h free=%0d uns=%0d rdy=%0b pos=%h",
                       a.status, a.dout, a.free, a.unsent, a.ready, a.wpos);
            end
          end
        end
        out_stall = burst_out ? 0 : $urandom_range(0, 15);
      end
      m_axis_tready <= (out_stall == 0);
      if (out_stall > 0) out_stall--;
    end
  end

  // Watchdog
  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
